// File: rtl/linear_scan_priority_queue_top_macros.svh
// Assertion macros for the linear-scan priority queue.
// Used by the top level; no other dependencies.
`ifndef LINEAR_SCAN_PRIORITY_QUEUE_TOP_MACROS_SVH
`define LINEAR_SCAN_PRIORITY_QUEUE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LSPQ_ASSERT_HOLDS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define LSPQ_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LSPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LSPQ_ASSERT_HOLDS(label, clk, rst, expr)
`define LSPQ_ASSERT_SAME(label, clk, rst, ante, cons)
`define LSPQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/lspq_pkg.sv
// Shared types and codes of the linear-scan priority queue.
// No dependencies; imported by the interfaces, the engine and the top level.
package lspq_pkg;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;

  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Priority sits above the value, as in the stored 48-bit word.
  typedef struct packed {
    logic signed [PRIO_W-1:0]  prio;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } res_t;

endpackage

// File: rtl/lspq_in_if.sv
// Command channel of the priority queue: valid/ready plus one command beat.
// Depends on lspq_pkg.
interface lspq_in_if
  import lspq_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic signed [VALUE_W-1:0] item_value;
  logic signed [PRIO_W-1:0]  item_priority;

  modport source (output valid, cmd, item_value, item_priority, input ready);
  modport sink (input valid, cmd, item_value, item_priority, output ready);
endinterface

// File: rtl/lspq_out_if.sv
// Result channel of the priority queue: valid/ready plus one result beat.
// Depends on lspq_pkg.
interface lspq_out_if
  import lspq_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic signed [VALUE_W-1:0] out_value;
  logic signed [PRIO_W-1:0]  out_priority;

  modport source (output valid, status, out_value, out_priority, input ready);
  modport sink (input valid, status, out_value, out_priority, output ready);
endinterface

// File: rtl/lspq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lspq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/lspq_engine.sv
// Command sequencer and scan datapath of the priority queue, around the entry RAM.
// Depends on lspq_pkg and lspq_ram.
module lspq_engine
  import lspq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);
  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam logic [IW-1:0] CAP_I = IW'(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]    state;
  logic [IW-1:0] head;
  logic [IW-1:0] fill;
  logic          first;
  logic [IW-1:0] rd_ptr;
  logic [IW-1:0] dat_ptr;
  logic [1:0]    cmd_r;
  entry_t        best;
  logic [AW-1:0] best_idx;
  entry_t        head_ent;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] raddr;
  logic [47:0]   rdata;
  entry_t        rd_ent;
  logic          take_new;
  entry_t        cand;
  logic [AW-1:0] cand_idx;
  entry_t        head_cur;
  logic          last;
  logic          accept;
  logic          is_full;
  logic          is_empty;
  logic [1:0]    idle_status;

  lspq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_HOLD);
  assign accept    = in_valid && in_ready;
  assign is_full   = (fill == CAP_I);
  assign is_empty  = (head >= fill);

  // Status of a command that finishes without a scan.
  assign idle_status = ((in_item.cmd == CMD_ENQ) && is_full) ? ST_FULL :
                       (((in_item.cmd == CMD_DEQ) || (in_item.cmd == CMD_PEEK)) && is_empty) ?
                       ST_EMPTY : ST_OK;

  // Data arriving from the RAM belongs to the slot at dat_ptr. The first beat of
  // a scan is the head entry, which is also what a dequeue moves into the gap.
  assign rd_ent   = entry_t'(rdata);
  assign take_new = first || (rd_ent.prio > best.prio);
  assign cand     = take_new ? rd_ent : best;
  assign cand_idx = take_new ? dat_ptr[AW-1:0] : best_idx;
  assign head_cur = first ? rd_ent : head_ent;
  assign last     = (IW'(dat_ptr + IW'(1)) == fill);

  assign raddr = (state == S_IDLE) ? head[AW-1:0] : rd_ptr[AW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = fill[AW-1:0];
    wdata = '{prio: in_item.prio, value: in_item.value};
    if (accept && (in_item.cmd == CMD_ENQ) && !is_full) begin
      we = 1'b1;
    end else if ((state == S_SCAN) && last && (cmd_r == CMD_DEQ)) begin
      we    = 1'b1;
      waddr = cand_idx;
      wdata = head_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      fill  <= '0;
      first <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_HOLD;
            if (in_item.cmd == CMD_ENQ) begin
              if (!is_full) begin
                fill <= IW'(fill + IW'(1));
              end
            end else if ((in_item.cmd == CMD_DEQ) || (in_item.cmd == CMD_PEEK)) begin
              if (!is_empty) begin
                state <= S_SCAN;
                first <= 1'b1;
              end
            end
          end
        end
        S_SCAN: begin
          first <= 1'b0;
          if (last) begin
            state <= S_HOLD;
            if (cmd_r == CMD_DEQ) begin
              head <= IW'(head + IW'(1));
            end
          end
        end
        S_HOLD: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      cmd_r   <= in_item.cmd;
      dat_ptr <= head;
      rd_ptr  <= IW'(head + IW'(1));
      if (accept) begin
        res <= '{status: idle_status, value: '0, prio: '0};
      end
    end else if (state == S_SCAN) begin
      best     <= cand;
      best_idx <= cand_idx;
      head_ent <= head_cur;
      dat_ptr  <= IW'(dat_ptr + IW'(1));
      rd_ptr   <= IW'(rd_ptr + IW'(1));
      if (last) begin
        res <= '{status: ST_OK, value: cand.value, prio: cand.prio};
      end
    end
  end
endmodule

// File: rtl/linear_scan_priority_queue_top.sv
// Top level of the linear-scan priority queue: engine plus the result register.
// Depends on lspq_pkg, lspq_in_if, lspq_out_if, lspq_engine and the macro header.
//
// Each command beat produces exactly one result beat. An enqueue, or a dequeue or
// peek on an empty queue, goes from acceptance straight to the engine's hold
// state; a dequeue or peek first scans the n live entries between the head and
// the fill index, reading the entry RAM through its single read port one slot
// per cycle. The next command is taken only after the engine has handed its
// result to the output register, so a stalled output holds it back as well.
// At most one command is in work at a time; a new command is taken while the
// previous result still waits in the output register. The RAM is not cleared
// after reset; only slots that were written are ever used. Slots freed by
// dequeue are not reused.
`include "linear_scan_priority_queue_top_macros.svh"

module linear_scan_priority_queue_top
  import lspq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic        clk,
  input logic        rst,
  lspq_in_if.sink    items,
  lspq_out_if.source results
);
  item_t in_item;
  logic  res_valid;
  logic  res_ready;
  res_t  res;
  logic  out_valid;
  res_t  out_res;

  assign in_item = '{cmd: items.cmd, value: items.item_value, prio: items.item_priority};

  lspq_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The output register frees the engine as soon as its result is captured.
  assign res_ready = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign results.valid        = out_valid;
  assign results.status       = out_res.status;
  assign results.out_value    = out_res.value;
  assign results.out_priority = out_res.prio;

  `LSPQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, items.valid && items.ready, !items.ready)
  `LSPQ_ASSERT_SAME(a_no_accept_while_holding, clk, rst, res_valid, !items.ready)
  `LSPQ_ASSERT_NEXT(a_handoff_lands, clk, rst, res_valid && res_ready, results.valid)
  `LSPQ_ASSERT_SAME(a_error_has_no_payload, clk, rst,
                    results.valid && (results.status != ST_OK),
                    (results.out_value == '0) && (results.out_priority == '0))
endmodule
